// ===== rtl/xyp_pkg.sv =====
// Package: widths, codes and the pipeline stage type of the pattern pixel block.
package xyp_pkg;

  localparam int COORD_BITS = 12;
  localparam int CONST_W    = 8;
  localparam int OP_W       = (COORD_BITS > CONST_W) ? COORD_BITS : CONST_W;
  localparam int VAL_W      = 2 * OP_W + 1;
  localparam int RAW_W      = 25;
  localparam int SHIFT_W    = 3;
  localparam int BYTE_W     = 8;

  // Divider: quotient bits resolved per pipeline stage.
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (OP_W + DIV_STEP - 1) / DIV_STEP;
  // Operand stage, ALU stage, then the divider stages.
  localparam int NUM_STAGES = DIV_STAGES + 2;

  localparam int OPC_W = 4;
  localparam int SEL_W = 2;

  localparam logic [OPC_W-1:0] OP_ADD = 4'd0;
  localparam logic [OPC_W-1:0] OP_SUB = 4'd1;
  localparam logic [OPC_W-1:0] OP_MUL = 4'd2;
  localparam logic [OPC_W-1:0] OP_DIV = 4'd3;
  localparam logic [OPC_W-1:0] OP_MOD = 4'd4;
  localparam logic [OPC_W-1:0] OP_AND = 4'd5;
  localparam logic [OPC_W-1:0] OP_OR  = 4'd6;
  localparam logic [OPC_W-1:0] OP_XOR = 4'd7;
  localparam logic [OPC_W-1:0] OP_SHL = 4'd8;
  localparam logic [OPC_W-1:0] OP_SHR = 4'd9;

  localparam logic [SEL_W-1:0] SEL_X     = 2'd0;
  localparam logic [SEL_W-1:0] SEL_Y     = 2'd1;
  localparam logic [SEL_W-1:0] SEL_CONST = 2'd2;

  // APB register map, one 32-bit word per register.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_OPERATION = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_SEL  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_SEL = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CONSTANT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd4;

  localparam logic [OPC_W-1:0]   RST_OPERATION = OP_SHR;
  localparam logic [SEL_W-1:0]   RST_LEFT_SEL  = SEL_X;
  localparam logic [SEL_W-1:0]   RST_RIGHT_SEL = SEL_Y;
  localparam logic [CONST_W-1:0] RST_CONSTANT  = 8'd18;
  localparam logic [BYTE_W-1:0]  RST_THRESHOLD = 8'd12;

  typedef struct packed {
    logic [OP_W-1:0]         a;
    logic [OP_W-1:0]         b;
    logic signed [VAL_W-1:0] val;   // non-divide result
    logic [OP_W:0]           rem;   // partial remainder
    logic [OP_W-1:0]         quo;   // dividend shifting out, quotient shifting in
  } stage_t;

endpackage

// ===== rtl/xyp_if.sv =====
// Handshake channels: coordinate requests in, pixel results out.
interface xyp_coord_if;
  logic                           valid;
  logic                           ready;
  logic [xyp_pkg::COORD_BITS-1:0] x_coord;
  logic [xyp_pkg::COORD_BITS-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface xyp_pixel_if;
  logic                             valid;
  logic                             ready;
  logic signed [xyp_pkg::RAW_W-1:0] raw_value;
  logic                             pixel_white;

  modport source (output valid, output raw_value, output pixel_white, input ready);
  modport sink   (input valid, input raw_value, input pixel_white, output ready);
endinterface

// ===== rtl/xy_expression_pattern_pixel.sv =====
// Pattern pixel generator: operand select, ALU, pipelined divider, threshold.
//
// Usage:
//   coord (sink) takes one (x_coord, y_coord) request per accepted handshake.
//   pixel (source) returns raw_value, the result of the configured operation
//   on the two selected operands, and pixel_white, set when the result is
//   non-negative and its low byte exceeds the threshold.
//   Registers sit on the APB port: operation, left_select, right_select,
//   operand_constant, threshold at byte addresses 0, 4, 8, 12, 16. Write them
//   only while no request is in flight.
// Timing:
//   One request per clock sustained while results are taken. Each request
//   passes one operand register, one ALU register, six divider registers
//   (two quotient bits each, 12-bit operands) and the output register. The
//   divider runs on every request, so all operations see the same latency.
// Reset (rst, synchronous): pipeline and output emptied, registers return to
//   shr, x, y, constant 18, threshold 12.
// Stall: each stage holds while the next one is full and stalled, so a full
//   stage only waits on a full successor; bubbles close up and coord.ready
//   drops only once every stage holds a request.
module xy_expression_pattern_pixel (
  input  logic                            clk,
  input  logic                            rst,
  xyp_coord_if.sink                       coord,
  xyp_pixel_if.source                     pixel,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [xyp_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [xyp_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [xyp_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import xyp_pkg::*;

  localparam int NP = NUM_STAGES;

  // Configuration registers
  logic [OPC_W-1:0]   operation;
  logic [SEL_W-1:0]   left_select;
  logic [SEL_W-1:0]   right_select;
  logic [CONST_W-1:0] operand_constant;
  logic [BYTE_W-1:0]  threshold;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;

  // Pipeline
  stage_t          p     [NP];
  stage_t          st_in [NP];
  logic [NP-1:0]   pv;
  logic [NP-1:0]   vin;
  logic [NP:0]     en;

  // Output register
  logic                    out_valid;
  logic signed [RAW_W-1:0] out_raw;
  logic                    out_white;
  logic signed [VAL_W-1:0] fin_val;
  logic                    fin_white;

  function automatic logic [OP_W-1:0] pick(input logic [SEL_W-1:0]      sel,
                                           input logic [COORD_BITS-1:0] x,
                                           input logic [COORD_BITS-1:0] y,
                                           input logic [CONST_W-1:0]    c);
    logic [OP_W-1:0] r;
    case (sel)
      SEL_X:     r = OP_W'(x);
      SEL_Y:     r = OP_W'(y);
      SEL_CONST: r = OP_W'(c);
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] alu(input logic [OPC_W-1:0] op,
                                                  input logic [OP_W-1:0]  a,
                                                  input logic [OP_W-1:0]  b);
    logic signed [VAL_W-1:0] ax;
    logic signed [VAL_W-1:0] bx;
    logic signed [VAL_W-1:0] r;
    logic [2*OP_W-1:0]       prod;
    logic [SHIFT_W-1:0]      sh;
    ax   = signed'(VAL_W'(a));
    bx   = signed'(VAL_W'(b));
    prod = a * b;
    sh   = b[SHIFT_W-1:0];
    case (op)
      OP_ADD:  r = ax + bx;
      OP_SUB:  r = ax - bx;
      OP_MUL:  r = signed'(VAL_W'(prod));
      OP_AND:  r = ax & bx;
      OP_OR:   r = ax | bx;
      OP_XOR:  r = ax ^ bx;
      OP_SHL:  r = ax << sh;
      OP_SHR:  r = ax >> sh;
      default: r = '0;   // div/mod come from the divider; unused codes give 0
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- APB
  assign pready    = 1'b1;
  assign reg_idx   = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation        <= RST_OPERATION;
      left_select      <= RST_LEFT_SEL;
      right_select     <= RST_RIGHT_SEL;
      operand_constant <= RST_CONSTANT;
      threshold        <= RST_THRESHOLD;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_OPERATION: operation        <= pwdata[OPC_W-1:0];
        REG_LEFT_SEL:  left_select      <= pwdata[SEL_W-1:0];
        REG_RIGHT_SEL: right_select     <= pwdata[SEL_W-1:0];
        REG_CONSTANT:  operand_constant <= pwdata[CONST_W-1:0];
        REG_THRESHOLD: threshold        <= pwdata[BYTE_W-1:0];
        default: ;     // unmapped words ignore writes
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OPERATION: prdata = CFG_DATA_W'(operation);
      REG_LEFT_SEL:  prdata = CFG_DATA_W'(left_select);
      REG_RIGHT_SEL: prdata = CFG_DATA_W'(right_select);
      REG_CONSTANT:  prdata = CFG_DATA_W'(operand_constant);
      REG_THRESHOLD: prdata = CFG_DATA_W'(threshold);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- flow control
  // A stage loads when it is empty or its content moves on this cycle.
  always_comb begin
    en[NP] = !out_valid || pixel.ready;
    for (int i = NP - 1; i >= 0; i--) begin
      en[i] = !pv[i] || en[i+1];
    end
  end

  assign coord.ready = en[0];
  assign vin         = {pv[NP-2:0], coord.valid};

  // ---------------------------------------------------------- stage logic
  // Stage 0: operand select. Stage 1: ALU, divider seeded with a.
  always_comb begin
    st_in[0].a   = pick(left_select, coord.x_coord, coord.y_coord, operand_constant);
    st_in[0].b   = pick(right_select, coord.x_coord, coord.y_coord, operand_constant);
    st_in[0].val = '0;
    st_in[0].rem = '0;
    st_in[0].quo = '0;

    st_in[1]     = p[0];
    st_in[1].val = alu(operation, p[0].a, p[0].b);
    st_in[1].rem = '0;
    st_in[1].quo = p[0].a;
  end

  // Restoring divider, DIV_STEP quotient bits per stage.
  for (genvar k = 2; k < NP; k++) begin : g_div
    logic [OP_W:0]   r;
    logic [OP_W-1:0] q;
    always_comb begin
      r = p[k-1].rem;
      q = p[k-1].quo;
      for (int j = 0; j < DIV_STEP; j++) begin
        if ((k - 2) * DIV_STEP + j < OP_W) begin
          r = {r[OP_W-1:0], q[OP_W-1]};
          q = {q[OP_W-2:0], 1'b0};
          if (r >= {1'b0, p[k-1].b}) begin
            r    = r - {1'b0, p[k-1].b};
            q[0] = 1'b1;
          end
        end
      end
      st_in[k]     = p[k-1];
      st_in[k].rem = r;
      st_in[k].quo = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      for (int i = 0; i < NP; i++) begin
        if (en[i]) begin
          pv[i] <= vin[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NP; i++) begin
      if (en[i]) begin
        p[i] <= st_in[i];
      end
    end
  end

  // ---------------------------------------------------------- result select
  always_comb begin
    case (operation)
      OP_DIV:  fin_val = (p[NP-1].b == '0) ? '0 : signed'(VAL_W'(p[NP-1].quo));
      OP_MOD:  fin_val = (p[NP-1].b == '0) ? '0 : signed'(VAL_W'(p[NP-1].rem));
      default: fin_val = p[NP-1].val;
    endcase
    // Negative results (sub only) are always black.
    fin_white = !fin_val[VAL_W-1] && (fin_val[BYTE_W-1:0] > threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en[NP]) begin
      out_valid <= pv[NP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[NP]) begin
      out_raw   <= signed'(RAW_W'(fin_val));
      out_white <= fin_white;
    end
  end

  assign pixel.valid       = out_valid;
  assign pixel.raw_value   = out_raw;
  assign pixel.pixel_white = out_white;

  // ---------------------------------------------------------- assertions
  // Input backpressure only when every stage and the output hold a request.
  a_full_on_stall : assert property (@(posedge clk) disable iff (rst)
    !coord.ready |-> (&pv) && out_valid)
    else $error("coord stalled with a free stage");

  // A new result only comes from a full last stage.
  a_out_source : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pv[NP-1]))
    else $error("result appeared without a request in the last stage");

  // Divider leaves a remainder below a nonzero divisor.
  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    pv[NP-1] && (p[NP-1].b != '0) |-> p[NP-1].rem < {1'b0, p[NP-1].b})
    else $error("divider remainder out of range");

  // White pixels carry a low byte above the threshold.
  a_white_byte : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_white |-> out_raw[BYTE_W-1:0] > threshold)
    else $error("white pixel with low byte at or below threshold");

endmodule

// ===== tb/xyp_pixel_checker.sv =====
// Checker: follows register traffic, predicts each pixel result and compares it.
module xyp_pixel_checker (
  input  logic                           clk,
  input  logic                           rst,
  xyp_coord_if                           coord,
  xyp_pixel_if                           pixel,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [xyp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [xyp_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [xyp_pkg::CFG_DATA_W-1:0] prdata,
  output int                             mismatch_count,
  output int                             pixels_checked,
  output int                             requests_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  import xyp_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    logic signed [RAW_W-1:0] raw;
    logic                    white;
  } pixel_expect_t;

  // shadow copy of the register file
  logic [OPC_W-1:0]   cfg_op;
  logic [SEL_W-1:0]   cfg_left;
  logic [SEL_W-1:0]   cfg_right;
  logic [CONST_W-1:0] cfg_const;
  logic [BYTE_W-1:0]  cfg_threshold;

  pixel_expect_t        expected_pixels [$];
  pixel_expect_t        oldest;
  logic [REG_IDX_W-1:0] reg_index;

  assign reg_index = paddr[CFG_ADDR_W-1:2];

  function automatic longint operand_of(input logic [SEL_W-1:0] sel,
                                        input logic [COORD_BITS-1:0] x,
                                        input logic [COORD_BITS-1:0] y);
    longint v;
    case (sel)
      SEL_X:     v = x;
      SEL_Y:     v = y;
      SEL_CONST: v = cfg_const;
      default:   v = 0;
    endcase
    return v;
  endfunction

  function automatic pixel_expect_t predict_pixel(input logic [COORD_BITS-1:0] x,
                                                  input logic [COORD_BITS-1:0] y);
    longint        lhs;
    longint        rhs;
    longint        value;
    pixel_expect_t p;
    lhs = operand_of(cfg_left, x, y);
    rhs = operand_of(cfg_right, x, y);
    case (cfg_op)
      OP_ADD:  value = lhs + rhs;
      OP_SUB:  value = lhs - rhs;
      OP_MUL:  value = lhs * rhs;
      OP_DIV:  value = (rhs == 0) ? 0 : lhs / rhs;
      OP_MOD:  value = (rhs == 0) ? 0 : lhs % rhs;
      OP_AND:  value = lhs & rhs;
      OP_OR:   value = lhs | rhs;
      OP_XOR:  value = lhs ^ rhs;
      OP_SHL:  value = lhs << rhs[SHIFT_W-1:0];
      OP_SHR:  value = lhs >> rhs[SHIFT_W-1:0];
      default: value = 0;
    endcase
    p.x     = x;
    p.y     = y;
    p.raw   = value[RAW_W-1:0];
    // negative results never beat the threshold
    p.white = (value >= 0) && (value[BYTE_W-1:0] > cfg_threshold);
    return p;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_word(input logic [REG_IDX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] w;
    w = '0;
    case (idx)
      REG_OPERATION: w[OPC_W-1:0]   = cfg_op;
      REG_LEFT_SEL:  w[SEL_W-1:0]   = cfg_left;
      REG_RIGHT_SEL: w[SEL_W-1:0]   = cfg_right;
      REG_CONSTANT:  w[CONST_W-1:0] = cfg_const;
      REG_THRESHOLD: w[BYTE_W-1:0]  = cfg_threshold;
      default:       w = '0;
    endcase
    return w;
  endfunction

  task automatic note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_op        = RST_OPERATION;
      cfg_left      = RST_LEFT_SEL;
      cfg_right     = RST_RIGHT_SEL;
      cfg_const     = RST_CONSTANT;
      cfg_threshold = RST_THRESHOLD;
      expected_pixels.delete();
      mismatch_count = 0;
      pixels_checked = 0;
      requests_in_flight <= 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_index)
            REG_OPERATION: cfg_op        = pwdata[OPC_W-1:0];
            REG_LEFT_SEL:  cfg_left      = pwdata[SEL_W-1:0];
            REG_RIGHT_SEL: cfg_right     = pwdata[SEL_W-1:0];
            REG_CONSTANT:  cfg_const     = pwdata[CONST_W-1:0];
            REG_THRESHOLD: cfg_threshold = pwdata[BYTE_W-1:0];
            default: ;
          endcase
        end else if (prdata !== reg_word(reg_index)) begin
          note_error($sformatf("register %0d read: expected 0x%0h, got 0x%0h",
                               reg_index, reg_word(reg_index), prdata));
        end
      end

      if (coord.valid && coord.ready) begin
        expected_pixels.push_back(predict_pixel(coord.x_coord, coord.y_coord));
      end

      if (pixel.valid && pixel.ready) begin
        if (expected_pixels.size() == 0) begin
          note_error($sformatf("unexpected pixel: raw_value %0d pixel_white %0b",
                               pixel.raw_value, pixel.pixel_white));
        end else begin
          oldest = expected_pixels.pop_front();
          pixels_checked++;
          if (pixel.raw_value !== oldest.raw || pixel.pixel_white !== oldest.white) begin
            note_error($sformatf({"pixel x=%0d y=%0d: expected raw_value %0d white %0b, ",
                                  "got raw_value %0d white %0b"},
                                 oldest.x, oldest.y, oldest.raw, oldest.white,
                                 pixel.raw_value, pixel.pixel_white));
          end
        end
      end

      requests_in_flight <= expected_pixels.size();
    end
  end

endmodule

// ===== tb/tb_xy_expression_pattern_pixel.sv =====
// Testbench top: clock, reset, register setup, coordinate stimulus and verdict.
module tb_xy_expression_pattern_pixel;
  timeunit 1ns;
  timeprecision 1ps;

  import xyp_pkg::*;

  // Run limits. The pipeline is 8 deep, so a short settle at the end is plenty.
  localparam int unsigned CYCLE_LIMIT     = 200_000;
  localparam int          RANDOM_REQUESTS = 850;
  localparam int          SETTLE_CYCLES   = 16;

  localparam logic [COORD_BITS-1:0] COORD_MAX        = '1;
  localparam logic [SEL_W-1:0]      SEL_UNUSED       = 2'd3;
  localparam logic [OPC_W-1:0]      OP_LAST_UNUSED   = '1;
  localparam logic [REG_IDX_W-1:0]  REG_FIRST_UNUSED = REG_THRESHOLD + 1'b1;
  localparam logic [REG_IDX_W-1:0]  REG_LAST_UNUSED  = '1;

  // Output-side backpressure styles, each held for a stretch of random length.
  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_CHOKED, SINK_PERIODIC} sink_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatch_count;
  int pixels_checked;
  int requests_in_flight;

  int requests_sent   = 0;
  int settings_used   = 0;
  int burst_left      = 0;

  int unsigned cycle_count = 0;
  sink_mode_t  sink_mode   = SINK_OPEN;
  int unsigned stall_left  = 0;
  logic [3:0]  stall_tick  = '0;

  logic [REG_IDX_W-1:0] all_regs [5] = '{REG_OPERATION, REG_LEFT_SEL, REG_RIGHT_SEL,
                                         REG_CONSTANT, REG_THRESHOLD};

  xyp_coord_if coord_ch ();
  xyp_pixel_if pixel_ch ();

  xy_expression_pattern_pixel dut (
    .clk     (clk),
    .rst     (rst),
    .coord   (coord_ch),
    .pixel   (pixel_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Prediction and comparison live in the checker; this module only drives.
  xyp_pixel_checker u_pixel_check (
    .clk                (clk),
    .rst                (rst),
    .coord              (coord_ch),
    .pixel              (pixel_ch),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .mismatch_count     (mismatch_count),
    .pixels_checked     (pixels_checked),
    .requests_in_flight (requests_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d requests still in flight",
               cycle_count, requests_in_flight);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result sink. Each stretch picks a stall style: always ready, coin flip,
  // mostly stalled, or a regular periodic stall window. Stall windows slide
  // against the sender's bursts so that holds land on every pipeline stage.
  initial begin
    pixel_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      stall_tick <= stall_tick + 1'b1;
      if (stall_left == 0) begin
        sink_mode  <= sink_mode_t'($urandom_range(0, 3));
        stall_left <= $urandom_range(20, 300);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (sink_mode)
        SINK_OPEN:   pixel_ch.ready <= 1'b1;
        SINK_COIN:   pixel_ch.ready <= 1'($urandom_range(0, 1));
        SINK_CHOKED: pixel_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     pixel_ch.ready <= (stall_tick[3:2] != 2'b11);
      endcase
    end
  end

  // One coordinate request. valid stays up across a burst; when the burst
  // runs out, valid drops for a random gap and a new burst length is drawn.
  // Occasional long bursts give stretches with no idling on the input side.
  task automatic send_coord(input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y);
    coord_ch.x_coord <= x;
    coord_ch.y_coord <= y;
    coord_ch.valid   <= 1'b1;
    do @(posedge clk); while (!coord_ch.ready);
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      coord_ch.valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
                                               : $urandom_range(0, 10);
    end
  endtask

  // Registers may only change with the pipe empty.
  task automatic wait_idle();
    coord_ch.valid <= 1'b0;
    do @(posedge clk); while (requests_in_flight != 0);
  endtask

  // APB transfer: setup cycle, access cycle, then psel low before the next
  // transfer, so psel never drops and rises in the same step.
  task automatic reg_access(input logic                  write,
                            input logic [REG_IDX_W-1:0]  idx,
                            input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reads are checked against the shadow registers in the checker.
  task automatic read_back();
    foreach (all_regs[i]) reg_access(1'b0, all_regs[i], '0);
  endtask

  // Field value with junk above the field now and then; the block must mask it.
  function automatic logic [CFG_DATA_W-1:0] padded(input logic [CFG_DATA_W-1:0] value,
                                                   input int field_w);
    logic [CFG_DATA_W-1:0] word;
    word = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom()) : '0;
    word = ((word >> field_w) << field_w) | value;
    return word;
  endfunction

  task automatic apply_settings(input logic [OPC_W-1:0]   op,
                                input logic [SEL_W-1:0]   left_sel,
                                input logic [SEL_W-1:0]   right_sel,
                                input logic [CONST_W-1:0] konst,
                                input logic [BYTE_W-1:0]  thr);
    reg_access(1'b1, REG_OPERATION, padded(op, OPC_W));
    reg_access(1'b1, REG_LEFT_SEL,  padded(left_sel, SEL_W));
    reg_access(1'b1, REG_RIGHT_SEL, padded(right_sel, SEL_W));
    reg_access(1'b1, REG_CONSTANT,  padded(konst, CONST_W));
    reg_access(1'b1, REG_THRESHOLD, padded(thr, BYTE_W));
    read_back();
    settings_used++;
  endtask

  // Directed check of one operation on x and y with reset constant/threshold.
  task automatic directed_pair(input logic [OPC_W-1:0]      op,
                               input logic [COORD_BITS-1:0] x0,
                               input logic [COORD_BITS-1:0] y0,
                               input logic [COORD_BITS-1:0] x1,
                               input logic [COORD_BITS-1:0] y1);
    wait_idle();
    apply_settings(op, SEL_X, SEL_Y, RST_CONSTANT, RST_THRESHOLD);
    send_coord(x0, y0);
    send_coord(x1, y1);
  endtask

  // Coordinates lean on the corners: zero, full scale and small values
  // (small divisors, shift amounts and byte-sized results).
  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return COORD_MAX;
      2:       return COORD_BITS'($urandom_range(0, 15));
      default: return COORD_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [SEL_W-1:0] rand_sel();
    return ($urandom_range(0, 9) == 0) ? SEL_UNUSED : SEL_W'($urandom_range(SEL_X, SEL_CONST));
  endfunction

  initial begin
    logic [OPC_W-1:0] op;
    int               random_start;

    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    coord_ch.valid   <= 1'b0;
    coord_ch.x_coord <= '0;
    coord_ch.y_coord <= '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values must read back before anything is written
    read_back();

    // ---- directed part ----
    // reset setting is x >> (y mod 8)
    send_coord(COORD_MAX, 12'd7);
    send_coord(12'hAAA, 12'h555);
    directed_pair(OP_ADD, COORD_MAX, COORD_MAX, '0, '0);
    // x < y: most negative result, pixel must stay black
    directed_pair(OP_SUB, '0, COORD_MAX, COORD_MAX, '0);
    // full-scale product is the largest raw value
    directed_pair(OP_MUL, COORD_MAX, COORD_MAX, 12'hAAA, 12'h555);
    // divide and modulo by zero give zero
    directed_pair(OP_DIV, COORD_MAX, '0, COORD_MAX, 12'd3);
    directed_pair(OP_MOD, COORD_MAX, '0, COORD_MAX, 12'd256);
    directed_pair(OP_AND, 12'hAAA, 12'h555, COORD_MAX, COORD_MAX);
    directed_pair(OP_OR,  12'hAAA, 12'h555, '0, '0);
    directed_pair(OP_XOR, COORD_MAX, 12'hAAA, COORD_MAX, COORD_MAX);
    // shift amount is y mod 8: 7, then 0
    directed_pair(OP_SHL, COORD_MAX, 12'd7, 12'd1, 12'd8);
    directed_pair(OP_SHR, COORD_MAX, 12'd8, COORD_MAX, 12'd15);
    // codes past shr return zero
    directed_pair(OP_LAST_UNUSED, COORD_MAX, COORD_MAX, 12'd1, 12'd1);

    // ---- random part ----
    // Each phase: drain, maybe poke an unmapped register (must be ignored),
    // write a fresh setting, read it back, then a random-length run of pixels.
    // The first two settings of every sixteen pin the threshold at its extremes.
    random_start = requests_sent;
    while (requests_sent - random_start < RANDOM_REQUESTS) begin
      wait_idle();
      if ($urandom_range(0, 3) == 0) begin
        reg_access(1'b1, REG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                   $urandom());
      end
      op = ($urandom_range(0, 7) == 0) ? OPC_W'(OP_LAST_UNUSED - $urandom_range(0, 5))
                                       : OPC_W'($urandom_range(OP_ADD, OP_SHR));
      case (settings_used % 16)
        0:       apply_settings(op, rand_sel(), rand_sel(), rand_byte(), '0);
        1:       apply_settings(op, rand_sel(), rand_sel(), rand_byte(), '1);
        default: apply_settings(op, rand_sel(), rand_sel(), rand_byte(), rand_byte());
      endcase
      repeat ($urandom_range(10, 50)) send_coord(rand_coord(), rand_coord());
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d coordinate requests under %0d register settings,",
             requests_sent, settings_used);
    $display("  with %0d pixel results compared and %0d mismatches",
             pixels_checked, mismatch_count);
    if (mismatch_count == 0 && requests_in_flight == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
